>>> hw/rtl/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants of the serial command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package scfp_pkg;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 15;
  localparam int PLEN_W   = 6;
  localparam int CFG_IDX_W = 2;

  // Frame layout.
  localparam int HEADER_BYTES     = 3;
  localparam int MAX_RESULTS      = 61;
  localparam int DEF_BUFFER_DEPTH = 64;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BYTE  = 2'd1;
  localparam logic [BYTE_W-1:0]    START_RESET    = 8'd2;
  localparam logic [BYTE_W-1:0]    STOP_RESET     = 8'd3;

  // Request from the frame control to the emitter.
  typedef struct packed {
    logic              start;
    logic [PLEN_W-1:0] plen;
  } emit_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/serial_command_frame_parser.sv
// ----------------------------------------------------------------------------
// serial_command_frame_parser
// Start/length/stop byte framing with address decode and payload readout.
// ----------------------------------------------------------------------------
// Each received byte is taken while no frame is being read out.
// When a stop byte completes a valid frame, input is held off while the
// emitter reads the frame back through the single read port of the frame
// store: the three header bytes for the address build first, then one result
// item per cycle (less when the output stalls), with the final item marked
// last. An empty payload gives one item without a byte. The store needs no
// clearing pass after reset; entries are only read after they were written,
// and reads and writes never share a cycle.
`default_nettype none

module serial_command_frame_parser #(
  parameter int BUFFER_DEPTH = scfp_pkg::DEF_BUFFER_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration writes.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [scfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [scfp_pkg::BYTE_W-1:0]       cfg_data,
  // Received bytes.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [scfp_pkg::BYTE_W-1:0]       rx_byte,
  // Result items.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [scfp_pkg::ADDR_W-1:0]            command_address,
  output logic [scfp_pkg::BYTE_W-1:0]            payload_byte,
  output logic [scfp_pkg::PLEN_W-1:0]            payload_length,
  output logic                                   has_byte,
  output logic                                   last
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int MaxLen =
    (scfp_pkg::HEADER_BYTES + scfp_pkg::MAX_RESULTS < BUFFER_DEPTH) ?
    (scfp_pkg::HEADER_BYTES + scfp_pkg::MAX_RESULTS) : BUFFER_DEPTH;

  logic [scfp_pkg::BYTE_W-1:0] start_byte;
  logic [scfp_pkg::BYTE_W-1:0] stop_byte;
  logic [scfp_pkg::BYTE_W-1:0] expected_length;
  logic [FW-1:0]               fill_count;
  logic                        overflow_flag;

  logic                        in_fire;
  logic                        is_start;
  logic                        is_stop;
  logic                        frame_ok;
  logic                        store_full;
  logic                        store_we;
  logic                        emit_busy;
  scfp_pkg::emit_req_t         req;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [scfp_pkg::BYTE_W-1:0] rd_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !emit_busy;
  assign in_fire   = in_valid && in_ready;

  // Byte classification; the start meaning wins over the stop meaning.
  assign is_start   = (rx_byte == start_byte);
  assign is_stop    = (rx_byte == stop_byte);
  assign store_full = (fill_count >= FW'(BUFFER_DEPTH));
  assign frame_ok   = (9'(fill_count) == {1'b0, expected_length})
                   && (expected_length >= 8'(scfp_pkg::HEADER_BYTES))
                   && ({1'b0, expected_length} <= 9'(MaxLen));

  assign store_we = in_fire && !is_start && !overflow_flag && !is_stop
                 && (expected_length != '0) && !store_full;

  assign req.start = in_fire && !is_start && !overflow_flag && is_stop && frame_ok;
  assign req.plen  = scfp_pkg::PLEN_W'(expected_length - 8'(scfp_pkg::HEADER_BYTES));

  // Configuration registers and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= scfp_pkg::START_RESET;
      stop_byte       <= scfp_pkg::STOP_RESET;
      expected_length <= '0;
      fill_count      <= '0;
      overflow_flag   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == scfp_pkg::REG_START_BYTE) begin
          start_byte <= cfg_data;
        end else if (cfg_index == scfp_pkg::REG_STOP_BYTE) begin
          stop_byte <= cfg_data;
        end
      end
      if (in_fire) begin
        priority if (is_start) begin
          expected_length <= '0;
          fill_count      <= '0;
          overflow_flag   <= 1'b0;
        end else if (overflow_flag) begin
          // Frame dropped until the next start byte.
        end else if (is_stop) begin
          if (frame_ok) begin
            expected_length <= '0;
            fill_count      <= '0;
          end
        end else if (expected_length == '0) begin
          expected_length <= rx_byte;
        end else if (store_full) begin
          overflow_flag <= 1'b1;
        end else begin
          fill_count <= fill_count + FW'(1);
        end
      end
    end
  end

  // Frame store.
  scfp_ram #(
    .WIDTH (scfp_pkg::BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (fill_count[AW-1:0]),
    .wdata (rx_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Frame readout.
  scfp_emitter #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_emitter (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .busy            (emit_busy),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .command_address (command_address),
    .payload_byte    (payload_byte),
    .payload_length  (payload_length),
    .has_byte        (has_byte),
    .last            (last)
  );

  // An item without a byte only ever closes an empty frame.
  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last && (payload_length == '0))
    else $error("item without byte is not an empty-frame item");

  // Overflow is only raised with the store full, and the count holds there.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (fill_count == FW'(BUFFER_DEPTH)))
    else $error("overflow flag set with store not full");

  // An accepted frame always starts the readout.
  a_emit_taken: assert property (@(posedge clk) disable iff (rst)
    req.start |=> emit_busy)
    else $error("frame accepted but readout did not start");

  // No write to the store while a frame is read out.
  a_no_write_in_readout: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !store_we)
    else $error("store write overlaps readout");

endmodule

`default_nettype wire

>>> hw/rtl/scfp_ram.sv
// ----------------------------------------------------------------------------
// scfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scfp_emitter.sv
// ----------------------------------------------------------------------------
// scfp_emitter
// Reads an accepted frame back from the store, builds the address and sends
// through an output register one item per payload byte, or one without a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module scfp_emitter #(
  parameter int BUFFER_DEPTH = scfp_pkg::DEF_BUFFER_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire scfp_pkg::emit_req_t               req,
  output logic                                   busy,
  output logic                                   rd_en,
  output logic [$clog2(BUFFER_DEPTH)-1:0]        rd_addr,
  input  wire logic [scfp_pkg::BYTE_W-1:0]       rd_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [scfp_pkg::ADDR_W-1:0]            command_address,
  output logic [scfp_pkg::BYTE_W-1:0]            payload_byte,
  output logic [scfp_pkg::PLEN_W-1:0]            payload_length,
  output logic                                   has_byte,
  output logic                                   last
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HDR   = 2'd1;
  localparam logic [1:0] S_PAY   = 2'd2;
  localparam logic [1:0] S_EMPTY = 2'd3;

  logic [1:0]                    state;
  logic [1:0]                    hidx;
  logic [scfp_pkg::ADDR_W-1:0]   acc;
  logic [scfp_pkg::ADDR_W-1:0]   acc_next;
  logic [AW-1:0]                 pos;
  logic [scfp_pkg::PLEN_W-1:0]   rem;
  logic [scfp_pkg::PLEN_W-1:0]   plen_r;
  logic                          out_free;
  logic                          hdr_done;

  assign busy     = (state != S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign hdr_done = (hidx == 2'(scfp_pkg::HEADER_BYTES));

  // Address accumulates as acc*10 + byte over the three header bytes.
  always_comb begin
    if (hidx == 2'd1) begin
      acc_next = {{(scfp_pkg::ADDR_W-scfp_pkg::BYTE_W){1'b0}}, rd_data};
    end else begin
      acc_next = (acc << 3) + (acc << 1)
               + {{(scfp_pkg::ADDR_W-scfp_pkg::BYTE_W){1'b0}}, rd_data};
    end
  end

  // Store read requests.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos;
    unique case (state)
      S_IDLE: begin
        rd_en   = req.start;
        rd_addr = '0;
      end
      S_HDR: begin
        if (hdr_done) begin
          rd_en   = (plen_r != '0);
          rd_addr = AW'(scfp_pkg::HEADER_BYTES);
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(hidx);
        end
      end
      S_PAY: begin
        rd_en   = out_free && (rem != 6'd1);
        rd_addr = pos + AW'(1);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = pos;
      end
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            plen_r <= req.plen;
            rem    <= req.plen;
            hidx   <= 2'd1;
            state  <= S_HDR;
          end
        end
        S_HDR: begin
          acc <= acc_next;
          if (hdr_done) begin
            pos   <= AW'(scfp_pkg::HEADER_BYTES);
            state <= (plen_r == '0) ? S_EMPTY : S_PAY;
          end else begin
            hidx <= hidx + 2'd1;
          end
        end
        S_PAY: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            command_address <= acc;
            payload_byte    <= rd_data;
            payload_length  <= plen_r;
            has_byte        <= 1'b1;
            last            <= (rem == 6'd1);
            if (rem == 6'd1) begin
              state <= S_IDLE;
            end else begin
              pos <= pos + AW'(1);
              rem <= rem - 6'd1;
            end
          end
        end
        default: begin
          // Empty payload: a single item without a byte.
          if (out_free) begin
            out_valid       <= 1'b1;
            command_address <= acc;
            payload_byte    <= '0;
            payload_length  <= '0;
            has_byte        <= 1'b0;
            last            <= 1'b1;
            state           <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> bench/serial_command_frame_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_parser_test
// Self-checking bench for the start/length/stop frame parser. Received bytes
// go in over a valid/ready channel with random gaps. A scoreboard predicts
// the result items of each accepted frame. A monitor checks every result item
// in order while the output side stalls at random.
// ----------------------------------------------------------------------------

module serial_command_frame_parser_test;

  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 10;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int NUM_PHASES    = 5;

  // Framing bytes used by the directed frames after the first register writes.
  localparam logic [scfp_pkg::BYTE_W-1:0] DIR_START = 8'h7E;
  localparam logic [scfp_pkg::BYTE_W-1:0] DIR_STOP  = 8'h7F;

  // Directed frame at the reset framing values.
  localparam logic [scfp_pkg::BYTE_W-1:0] RESET_SEQ [7] = '{
    scfp_pkg::START_RESET, 8'h04, 8'hFF, 8'h00, 8'h09, 8'h80, scfp_pkg::STOP_RESET
  };

  // Zero byte before the length, empty payload, short length, length
  // mismatch followed by the missing byte, and the largest address.
  localparam logic [scfp_pkg::BYTE_W-1:0] DIRECTED_SEQ [20] = '{
    DIR_START, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, DIR_STOP,
    8'h02, 8'hAA, 8'hBB, DIR_STOP,
    DIR_START, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'h11, DIR_STOP,
    8'hEE, DIR_STOP
  };

  // Framing settings of the random phases. Phase 3 picks its own pair.
  localparam logic [scfp_pkg::BYTE_W-1:0] PHASE_START [NUM_PHASES] = '{
    8'h00, 8'hFF, 8'h5A, 8'h00, scfp_pkg::START_RESET
  };
  localparam logic [scfp_pkg::BYTE_W-1:0] PHASE_STOP [NUM_PHASES] = '{
    8'hFF, 8'h00, 8'h5A, 8'h00, scfp_pkg::STOP_RESET
  };
  localparam int PHASE_ITEMS [NUM_PHASES] = '{6, 6, 5, 10, 6};

  typedef struct packed {
    logic [scfp_pkg::ADDR_W-1:0] addr;
    logic [scfp_pkg::BYTE_W-1:0] data;
    logic [scfp_pkg::PLEN_W-1:0] plen;
    logic                        has;
    logic                        is_last;
  } frame_result_t;

  // Scoreboard: tracks the framing state and holds the pending result items.
  class frame_scoreboard;
    logic [scfp_pkg::BYTE_W-1:0] start_val;
    logic [scfp_pkg::BYTE_W-1:0] stop_val;
    logic [scfp_pkg::BYTE_W-1:0] store [scfp_pkg::DEF_BUFFER_DEPTH];
    int                          exp_len;
    int                          fill;
    bit                          overflow;
    frame_result_t               pending_q[$];
    int                          errors;

    function new();
      errors    = 0;
      start_val = scfp_pkg::START_RESET;
      stop_val  = scfp_pkg::STOP_RESET;
      clear_frame();
    endfunction

    function void clear_frame();
      exp_len  = 0;
      fill     = 0;
      overflow = 1'b0;
    endfunction

    function void write_reg(logic [scfp_pkg::CFG_IDX_W-1:0] idx,
                            logic [scfp_pkg::BYTE_W-1:0] data);
      case (idx)
        scfp_pkg::REG_START_BYTE: start_val = data;
        scfp_pkg::REG_STOP_BYTE:  stop_val  = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Queue the address item(s) of a complete frame, then clear the frame.
    function void emit_frame();
      int            addr;
      int            plen;
      frame_result_t r;
      addr = int'(store[0]) * 100 + int'(store[1]) * 10 + int'(store[2]);
      plen = exp_len - scfp_pkg::HEADER_BYTES;
      r.addr = scfp_pkg::ADDR_W'(addr);
      r.plen = scfp_pkg::PLEN_W'(plen);
      if (plen == 0) begin
        r.data    = '0;
        r.has     = 1'b0;
        r.is_last = 1'b1;
        pending_q.push_back(r);
      end else begin
        for (int i = 0; i < plen; i++) begin
          r.data    = store[i + scfp_pkg::HEADER_BYTES];
          r.has     = 1'b1;
          r.is_last = (i == plen - 1);
          pending_q.push_back(r);
        end
      end
      clear_frame();
    endfunction

    // Advance the framing state by one accepted byte.
    function void note_byte(logic [scfp_pkg::BYTE_W-1:0] b);
      if (b == start_val) begin
        clear_frame();
      end else if (overflow) begin
        // Everything but the start byte is dropped after an overflow.
      end else if (b == stop_val) begin
        if (fill == exp_len && exp_len >= scfp_pkg::HEADER_BYTES &&
            exp_len - scfp_pkg::HEADER_BYTES <= scfp_pkg::MAX_RESULTS &&
            exp_len <= scfp_pkg::DEF_BUFFER_DEPTH) begin
          emit_frame();
        end
      end else if (exp_len == 0) begin
        exp_len = int'(b);
      end else if (fill >= scfp_pkg::DEF_BUFFER_DEPTH) begin
        overflow = 1'b1;
      end else begin
        store[fill] = b;
        fill++;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) begin
        $display("[%0t] error: %s", $time, msg);
      end
    endtask

    // Compare one result item against the oldest pending one.
    task check_result(frame_result_t got);
      frame_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected item addr=%0d byte=%02h len=%0d has=%0b last=%0b",
                         got.addr, got.data, got.plen, got.has, got.is_last));
      end else begin
        want = pending_q.pop_front();
        if (got.addr !== want.addr || got.data !== want.data || got.plen !== want.plen ||
            got.has !== want.has || got.is_last !== want.is_last) begin
          report($sformatf({"item addr=%0d byte=%02h len=%0d has=%0b last=%0b, ",
                            "want %0d %02h %0d %0b %0b"},
                           got.addr, got.data, got.plen, got.has, got.is_last,
                           want.addr, want.data, want.plen, want.has, want.is_last));
        end
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [scfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scfp_pkg::BYTE_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [scfp_pkg::BYTE_W-1:0]    rx_byte = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [scfp_pkg::ADDR_W-1:0]    command_address;
  logic [scfp_pkg::BYTE_W-1:0]    payload_byte;
  logic [scfp_pkg::PLEN_W-1:0]    payload_length;
  logic                           has_byte;
  logic                           last;

  frame_scoreboard sb;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  bit  send_burst   = 1'b0;
  bit  recv_burst   = 1'b0;

  serial_command_frame_parser dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .command_address (command_address),
    .payload_byte    (payload_byte),
    .payload_length  (payload_length),
    .has_byte        (has_byte),
    .last            (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, a few long; none in a burst stretch.
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A payload or header byte that is neither framing byte.
  function automatic logic [scfp_pkg::BYTE_W-1:0] frame_byte();
    logic [scfp_pkg::BYTE_W-1:0] b;
    do begin
      b = scfp_pkg::BYTE_W'($urandom_range(0, 255));
    end while (b == sb.start_val || b == sb.stop_val);
    return b;
  endfunction

  // Frame length, mostly small, sometimes up to the full store.
  function automatic int pick_length(int lo, int hi);
    int len;
    do begin
      if (hi > 10 && $urandom_range(0, 99) < 10) begin
        len = ($urandom_range(0, 2) == 0) ? hi : $urandom_range(11, hi);
      end else begin
        len = $urandom_range(lo, (hi < 10) ? hi : 10);
      end
    end while (len == int'(sb.start_val) || len == int'(sb.stop_val));
    return len;
  endfunction

  // Offer one byte and wait until it is accepted.
  task automatic send_byte(logic [scfp_pkg::BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    items_sent++;
  endtask

  // Optional start and zero bytes, the length byte, frame bytes, the stop byte.
  task automatic send_frame(int len, int count, bit lead, int zeros);
    if (lead) send_byte(sb.start_val);
    repeat (zeros) send_byte(8'h00);
    send_byte(scfp_pkg::BYTE_W'(len));
    repeat (count) send_byte(frame_byte());
    send_byte(sb.stop_val);
  endtask

  // Stop offering items until every pending result item has come.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [scfp_pkg::CFG_IDX_W-1:0] idx,
                              logic [scfp_pkg::BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A frame that fills the whole store and one byte more, then the recovery.
  task automatic send_overflow();
    send_frame(scfp_pkg::DEF_BUFFER_DEPTH, scfp_pkg::DEF_BUFFER_DEPTH + 1, 1'b1, 0);
    send_frame(5, 5, 1'b0, 0);
    send_frame(5, 5, 1'b1, 0);
  endtask

  // Random traffic: mostly well-formed frames, the rest broken or noise.
  task automatic run_random(int budget);
    int stop_at;
    int r;
    int len;
    bit zero_ok;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      r       = $urandom_range(0, 99);
      zero_ok = (sb.start_val != 8'h00 && sb.stop_val != 8'h00);
      if (r < 70) begin
        len = pick_length(scfp_pkg::HEADER_BYTES, scfp_pkg::DEF_BUFFER_DEPTH);
        send_frame(len, len, $urandom_range(0, 99) < 85, 0);
      end else if (r < 80) begin
        len = pick_length(scfp_pkg::HEADER_BYTES, 10);
        send_frame(len, $urandom_range(0, 1) ? len - 1 : len + 1, 1'b1, 0);
      end else if (r < 86) begin
        len = pick_length(1, 2);
        send_frame(len, len, 1'b1, 0);
      end else if (r < 95) begin
        repeat ($urandom_range(1, 3)) send_byte(scfp_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        len = pick_length(scfp_pkg::HEADER_BYTES, 10);
        send_frame(len, len, 1'b1, zero_ok ? $urandom_range(1, 2) : 0);
      end
    end
  endtask

  // Output side: random stalls, plus one long hold-off while input keeps coming.
  initial begin : receiver
    bit held;
    int stall;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER && in_valid) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if ($urandom_range(0, 9) == 0) recv_burst = !recv_burst;
      stall = pick_gap(recv_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check every accepted result item.
  always @(posedge clk) begin : result_monitor
    frame_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = {command_address, payload_byte, payload_length, has_byte, last};
      sb.check_result(got);
      results_seen++;
    end
  end

  // End the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [scfp_pkg::BYTE_W-1:0] s_val;
    logic [scfp_pkg::BYTE_W-1:0] p_val;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frame at the reset framing values.
    foreach (RESET_SEQ[i]) send_byte(RESET_SEQ[i]);
    wait_idle();

    // Directed special cases with their own framing bytes.
    write_config(scfp_pkg::REG_START_BYTE, DIR_START);
    write_config(scfp_pkg::REG_STOP_BYTE, DIR_STOP);
    foreach (DIRECTED_SEQ[i]) send_byte(DIRECTED_SEQ[i]);
    wait_idle();

    // Random phases over several framing settings, extremes included.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      s_val = PHASE_START[ph];
      p_val = PHASE_STOP[ph];
      if (ph == 3) begin
        // Keep lengths one and two free of the start byte for the short-length frames.
        s_val = scfp_pkg::BYTE_W'($urandom_range(3, 255));
        do begin
          p_val = scfp_pkg::BYTE_W'($urandom_range(0, 255));
        end while (p_val == s_val);
      end
      write_config(scfp_pkg::REG_START_BYTE, s_val);
      write_config(scfp_pkg::REG_STOP_BYTE, p_val);
      if (ph == 0) send_overflow();
      if (ph == 3) begin
        // Sender pauses mid-phase until the output has caught up.
        run_random(PHASE_ITEMS[ph] / 2);
        wait_idle();
        run_random(PHASE_ITEMS[ph] - PHASE_ITEMS[ph] / 2);
      end else begin
        run_random(PHASE_ITEMS[ph]);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
